/* sv/pmu_pkg.sv */
// shared types and constants for the polynomial multiplier unit
// used by every module of the block, no dependencies
package pmu_pkg;

  localparam int MAX_TERMS   = 16;
  localparam int COEF_W      = 16;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 5;
  localparam int POW_W       = 5;
  localparam int MUL_W       = 2 * COEF_W;
  localparam int PROD_W      = 36;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 48;

  typedef struct packed {
    logic signed [COEF_W-1:0] f_coef;
    logic signed [COEF_W-1:0] g_coef;
    logic [IDX_W-1:0]         idx;
    logic                     keep;
    logic                     last_in;
  } job_t;

  typedef enum logic [2:0] {
    BK_LOAD,
    BK_START,
    BK_ISSUE,
    BK_DRAIN,
    BK_OUT
  } back_state_t;

endpackage

/* sv/pmu_front.sv */
// front part: accepts coefficient pairs and tags each with its store slot
// depends on pmu_pkg
module pmu_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pmu_pkg::IN_DATA_W-1:0] s_tdata,  // f_coef, g_coef
  input  logic                          s_tlast,  // last_in
  output logic                          q_push,
  input  logic                          q_ready,
  output pmu_pkg::job_t                 q_job
);

  logic [pmu_pkg::CNT_W-1:0] load_count;
  logic [pmu_pkg::CNT_W-1:0] load_count_next;
  logic                      keep;

  assign s_tready = q_ready;
  assign q_push   = s_tvalid & q_ready;
  assign keep     = (load_count < pmu_pkg::CNT_W'(pmu_pkg::MAX_TERMS));

  always_comb begin
    q_job.f_coef  = s_tdata[pmu_pkg::COEF_W-1:0];
    q_job.g_coef  = s_tdata[2*pmu_pkg::COEF_W-1:pmu_pkg::COEF_W];
    q_job.idx     = load_count[pmu_pkg::IDX_W-1:0];
    q_job.keep    = keep;
    q_job.last_in = s_tlast;
  end

  always_comb begin
    load_count_next = load_count;
    if (q_push) begin
      if (s_tlast) begin
        load_count_next = '0;
      end else if (keep) begin
        load_count_next = load_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else begin
      load_count <= load_count_next;
    end
  end

endmodule

/* sv/pmu_queue.sv */
// short queue of tagged coefficient pairs between front and back
// depends on pmu_pkg
module pmu_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          ready,
  input  pmu_pkg::job_t push_job,
  output logic          valid,
  input  logic          pop,
  output pmu_pkg::job_t pop_job
);

  pmu_pkg::job_t              entries [pmu_pkg::QUEUE_DEPTH];
  logic [pmu_pkg::QPTR_W-1:0] wr_ptr;
  logic [pmu_pkg::QPTR_W-1:0] rd_ptr;
  logic [pmu_pkg::QCNT_W-1:0] fill;
  logic                       do_push;
  logic                       do_pop;

  assign ready   = (fill != pmu_pkg::QCNT_W'(pmu_pkg::QUEUE_DEPTH));
  assign valid   = (fill != '0);
  assign do_push = push & ready;
  assign do_pop  = pop & valid;
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* sv/pmu_back.sv */
// back part: stores the operands and runs the multiply-accumulate per power
// depends on pmu_pkg
module pmu_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  output logic                           q_pop,
  input  pmu_pkg::job_t                  q_job,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [pmu_pkg::OUT_DATA_W-1:0] m_tdata,  // prod_coef, power
  output logic                           m_tlast,  // last_out
  output logic                           m_tuser   // overflow
);

  logic signed [pmu_pkg::COEF_W-1:0] f_store [pmu_pkg::MAX_TERMS];
  logic signed [pmu_pkg::COEF_W-1:0] g_store [pmu_pkg::MAX_TERMS];

  pmu_pkg::back_state_t state;
  pmu_pkg::back_state_t state_next;

  logic [pmu_pkg::IDX_W-1:0]         f_top;
  logic [pmu_pkg::IDX_W-1:0]         g_top;
  logic                              f_nonzero;
  logic                              g_nonzero;
  logic                              dropped;
  logic [pmu_pkg::POW_W-1:0]         power;
  logic [pmu_pkg::POW_W-1:0]         deg;
  logic [pmu_pkg::IDX_W-1:0]         term;
  logic [pmu_pkg::IDX_W-1:0]         term_hi;
  logic                              rd_valid;
  logic                              mul_valid;
  logic signed [pmu_pkg::COEF_W-1:0] f_rd;
  logic signed [pmu_pkg::COEF_W-1:0] g_rd;
  logic signed [pmu_pkg::MUL_W-1:0]  mul;
  logic signed [pmu_pkg::PROD_W-1:0] acc;
  logic [pmu_pkg::POW_W-1:0]         g_idx_full;
  logic [pmu_pkg::POW_W-1:0]         power_next;
  logic [pmu_pkg::POW_W-1:0]         f_top_ext;
  logic [pmu_pkg::POW_W-1:0]         g_top_ext;
  logic [pmu_pkg::POW_W-1:0]         lo_next;
  logic [pmu_pkg::POW_W-1:0]         hi_next;
  logic                              issue;
  logic                              load_out;
  logic                              store_en;
  logic                              both_nonzero;

  assign f_top_ext    = pmu_pkg::POW_W'(f_top);
  assign g_top_ext    = pmu_pkg::POW_W'(g_top);
  assign both_nonzero = f_nonzero & g_nonzero;
  assign g_idx_full   = power - pmu_pkg::POW_W'(term);
  assign power_next   = (state == pmu_pkg::BK_START) ? '0 : power + 1'b1;
  assign lo_next      = (power_next > g_top_ext) ? power_next - g_top_ext : '0;
  assign hi_next      = (power_next < f_top_ext) ? power_next : f_top_ext;
  assign store_en     = q_pop & q_job.keep;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pmu_pkg::BK_LOAD: begin
        if (q_valid && q_job.last_in) begin
          state_next = pmu_pkg::BK_START;
        end
      end
      pmu_pkg::BK_START: begin
        state_next = both_nonzero ? pmu_pkg::BK_ISSUE : pmu_pkg::BK_OUT;
      end
      pmu_pkg::BK_ISSUE: begin
        if (term == term_hi) begin
          state_next = pmu_pkg::BK_DRAIN;
        end
      end
      pmu_pkg::BK_DRAIN: begin
        if (!rd_valid && !mul_valid) begin
          state_next = pmu_pkg::BK_OUT;
        end
      end
      pmu_pkg::BK_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = (power == deg) ? pmu_pkg::BK_LOAD : pmu_pkg::BK_ISSUE;
        end
      end
      default: state_next = pmu_pkg::BK_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop    = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state)
      pmu_pkg::BK_LOAD:  q_pop    = q_valid;
      pmu_pkg::BK_ISSUE: issue    = 1'b1;
      pmu_pkg::BK_OUT:   load_out = !m_tvalid || m_tready;
      default: begin
        q_pop    = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmu_pkg::BK_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // operand stores
  always_ff @(posedge clk) begin
    if (store_en) begin
      f_store[q_job.idx] <= q_job.f_coef;
      g_store[q_job.idx] <= q_job.g_coef;
    end
    f_rd <= f_store[term];
    g_rd <= g_store[g_idx_full[pmu_pkg::IDX_W-1:0]];
    mul  <= f_rd * g_rd;
  end

  // load bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      f_top     <= '0;
      g_top     <= '0;
      f_nonzero <= 1'b0;
      g_nonzero <= 1'b0;
      dropped   <= 1'b0;
    end else if (load_out && power == deg) begin
      f_top     <= '0;
      g_top     <= '0;
      f_nonzero <= 1'b0;
      g_nonzero <= 1'b0;
      dropped   <= 1'b0;
    end else if (q_pop) begin
      if (!q_job.keep) begin
        dropped <= 1'b1;
      end else begin
        if (q_job.f_coef != '0) begin
          f_top     <= q_job.idx;
          f_nonzero <= 1'b1;
        end
        if (q_job.g_coef != '0) begin
          g_top     <= q_job.idx;
          g_nonzero <= 1'b1;
        end
      end
    end
  end

  // term sequencing and accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      mul_valid <= 1'b0;
    end else begin
      rd_valid  <= issue;
      mul_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pmu_pkg::BK_START) begin
      power   <= '0;
      deg     <= both_nonzero ? f_top_ext + g_top_ext : '0;
      term    <= lo_next[pmu_pkg::IDX_W-1:0];
      term_hi <= hi_next[pmu_pkg::IDX_W-1:0];
      acc     <= '0;
    end else if (load_out && power != deg) begin
      power   <= power_next;
      term    <= lo_next[pmu_pkg::IDX_W-1:0];
      term_hi <= hi_next[pmu_pkg::IDX_W-1:0];
      acc     <= '0;
    end else begin
      if (issue && term != term_hi) begin
        term <= term + 1'b1;
      end
      if (mul_valid) begin
        acc <= acc + pmu_pkg::PROD_W'(mul);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {{(pmu_pkg::OUT_DATA_W - pmu_pkg::PROD_W - pmu_pkg::POW_W){1'b0}},
                  power, acc};
      m_tlast <= (power == deg);
      m_tuser <= dropped;
    end
  end

endmodule

/* sv/polynomial_multiplier_unit.sv */
// top level of the polynomial multiplier unit: front, queue and back
// depends on pmu_pkg, pmu_front, pmu_queue, pmu_back
// loading: one transaction per cycle while the queue has room
// product: each coefficient accumulates its terms = overlapping pairs, at most 16
// first result via start, issue, drain and output states; zero product: start then output
// sync rst clears control state except power/term/deg; operand stores stay undefined
module polynomial_multiplier_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [pmu_pkg::IN_DATA_W-1:0]  s_tdata,   // f_coef, g_coef
  input  logic                           s_tlast,   // last_in
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [pmu_pkg::OUT_DATA_W-1:0] m_tdata,   // prod_coef, power
  output logic                           m_tlast,   // last_out
  output logic                           m_tuser    // overflow
);

  logic          q_push;
  logic          q_ready;
  logic          q_valid;
  logic          q_pop;
  pmu_pkg::job_t push_job;
  pmu_pkg::job_t pop_job;

  pmu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_push   (q_push),
    .q_ready  (q_ready),
    .q_job    (push_job)
  );

  pmu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .ready    (q_ready),
    .push_job (push_job),
    .valid    (q_valid),
    .pop      (q_pop),
    .pop_job  (pop_job)
  );

  pmu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_job    (pop_job),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
